@@ design/assert_macros.svh @@
// Assertion helpers shared by the deframer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the same cycle
`define LPD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Property whose consequence is checked in the cycle after the antecedent
`define LPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/lpd_pkg.sv @@
package lpd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 16;

  // Two length bytes lead every packet
  localparam logic [LEN_W-1:0] HEADER_BYTES = 16'd2;
  localparam logic [LEN_W-1:0] MIN_LEN_RST  = 16'd3;

  // Parser phase, one-hot
  typedef enum logic [3:0] {
    PH_LEN_LO = 4'b0001,
    PH_LEN_HI = 4'b0010,
    PH_DATA   = 4'b0100,
    PH_HALT   = 4'b1000
  } lpd_phase_t;

  // One result beat
  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              last_byte;
    logic              length_error;
  } lpd_res_t;

endpackage

@@ design/lpd_in_if.sv @@
interface lpd_in_if;
  logic                       valid;
  logic                       ready;
  logic [lpd_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ design/lpd_out_if.sv @@
interface lpd_out_if;
  logic                       valid;
  logic                       ready;
  logic [lpd_pkg::BYTE_W-1:0] payload_byte;
  logic                       last_byte;
  logic                       length_error;

  modport source (output valid, output payload_byte, output last_byte,
                  output length_error, input ready);
  modport sink   (input valid, input payload_byte, input last_byte,
                  input length_error, output ready);
endinterface

@@ design/lpd_parser.sv @@
`include "assert_macros.svh"

module lpd_parser (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [lpd_pkg::LEN_W-1:0]    cfg_wr_data,
  input  logic                         in_fire,
  input  logic [lpd_pkg::BYTE_W-1:0]   rx_byte,
  output logic                         res_valid,
  output lpd_pkg::lpd_res_t            res
);
  import lpd_pkg::*;

  lpd_phase_t        phase_r, phase_nxt;
  logic [BYTE_W-1:0] len_lo_r, len_lo_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [LEN_W-1:0]  min_len_r;
  logic [LEN_W-1:0]  decl_len;

  assign decl_len = {rx_byte, len_lo_r};

  // Phase decode for the accepted beat
  always_comb begin
    phase_nxt        = phase_r;
    len_lo_nxt       = len_lo_r;
    rem_nxt          = rem_r;
    res_valid        = 1'b0;
    res.payload_byte = rx_byte;
    res.last_byte    = 1'b0;
    res.length_error = 1'b0;
    if (in_fire) begin
      unique case (phase_r)
        PH_LEN_LO: begin
          len_lo_nxt = rx_byte;
          phase_nxt  = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          if ((decl_len < min_len_r) || (decl_len < HEADER_BYTES)) begin
            phase_nxt        = PH_HALT;
            res_valid        = 1'b1;
            res.payload_byte = '0;
            res.length_error = 1'b1;
          end else begin
            rem_nxt   = decl_len - HEADER_BYTES;
            phase_nxt = (decl_len == HEADER_BYTES) ? PH_LEN_LO : PH_DATA;
          end
        end
        PH_DATA: begin
          res_valid = 1'b1;
          if (rem_r <= 16'd1) begin
            rem_nxt       = '0;
            phase_nxt     = PH_LEN_LO;
            res.last_byte = 1'b1;
          end else begin
            rem_nxt = rem_r - 16'd1;
          end
        end
        default: begin
          // halted: drop everything until reset
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_LEN_LO;
      len_lo_r  <= '0;
      rem_r     <= '0;
      min_len_r <= MIN_LEN_RST;
    end else begin
      phase_r  <= phase_nxt;
      len_lo_r <= len_lo_nxt;
      rem_r    <= rem_nxt;
      if (cfg_wr_en) begin
        min_len_r <= cfg_wr_data;
      end
    end
  end

  `LPD_ASSERT_NEXT(a_halt_sticky, clk, rst_n, phase_r == PH_HALT, phase_r == PH_HALT, "halt left")
  `LPD_ASSERT_NOW(a_data_rem, clk, rst_n, phase_r == PH_DATA, rem_r != '0, "data with no bytes left")
  `LPD_ASSERT_NOW(a_err_src, clk, rst_n, res_valid && res.length_error, phase_r == PH_LEN_HI, "error outside header")

endmodule

@@ design/lpd_out_buf.sv @@
`include "assert_macros.svh"

module lpd_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  input  lpd_pkg::lpd_res_t  push_data,
  output logic               push_ready,
  output logic               out_valid,
  output lpd_pkg::lpd_res_t  out_data,
  input  logic               out_ready
);
  import lpd_pkg::*;

  logic     out_valid_r, out_valid_nxt;
  logic     skid_valid_r, skid_valid_nxt;
  lpd_res_t out_data_r, out_data_nxt;
  lpd_res_t skid_data_r, skid_data_nxt;
  logic     pop;

  assign pop        = out_valid_r && out_ready;
  assign push_ready = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  // Output register with one skid entry behind it
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (push_valid) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = push_data;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (push_valid) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  `LPD_ASSERT_NOW(a_skid_behind, clk, rst_n, skid_valid_r, out_valid_r, "skid full, output empty")
  `LPD_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid_r && !out_ready, out_valid_r && (out_data_r == $past(out_data_r)), "stalled beat changed")

endmodule

@@ design/length_prefix_deframer_unit.sv @@
// Channel  Dir  Payload                                        Handshake
// in_ch    in   rx_byte[7:0]                                   valid/ready
// out_ch   out  payload_byte[7:0], last_byte, length_error     valid/ready
// cfg_     in   cfg_wr_data[15:0] = min_length                 cfg_wr_en
//
// One byte is accepted per cycle while in_ch.ready is high. A two-entry
// output stage (output + skid register) holds the result beats; it keeps
// in_ch.ready high while one result waits, so it drops only when two
// results are held. Reset (rst_n low, synchronous) returns to the low
// length byte, clears the halt and loads min_length with 3.
module length_prefix_deframer_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  lpd_in_if.sink                    in_ch,
  lpd_out_if.source                 out_ch,
  input  logic                      cfg_wr_en,
  input  logic [lpd_pkg::LEN_W-1:0] cfg_wr_data
);
  import lpd_pkg::*;

  logic     buf_ready;
  logic     in_fire;
  logic     res_valid;
  lpd_res_t res;
  lpd_res_t out_data;

  assign in_ch.ready = buf_ready;
  assign in_fire     = in_ch.valid && buf_ready;

  // Header decode and payload tagging
  lpd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_fire     (in_fire),
    .rx_byte     (in_ch.rx_byte),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Result staging toward the sink
  lpd_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (res_valid),
    .push_data  (res),
    .push_ready (buf_ready),
    .out_valid  (out_ch.valid),
    .out_data   (out_data),
    .out_ready  (out_ch.ready)
  );

  assign out_ch.payload_byte = out_data.payload_byte;
  assign out_ch.last_byte    = out_data.last_byte;
  assign out_ch.length_error = out_data.length_error;

endmodule
